// ----- design/tstt_pkg.sv -----
package tstt_pkg;

    // default geometry of the table
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ID_BITS_DEF       = 24;

    // fixed field widths of the command and result channels
    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = 7;
    localparam int PURGE_BITS = 16;

    // configuration register indexes and reset values
    localparam int                  CFG_IDX_BITS       = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_PER_EMITTER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PURGE_INTERVAL  = 2'd1;
    localparam logic [PURGE_BITS-1:0]   PURGE_INTERVAL_RST  = 16'd2000;

    // saturation point of the removal count
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_PURGE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                  one_per_emitter;
        logic [PURGE_BITS-1:0] purge_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] stopped_count;
        logic                  is_playing;
        logic                  accepted;
        logic                  table_full;
    } t_result;

endpackage

// ----- design/tstt_mem.sv -----
module tstt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 90,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // one read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tstt_ctrl.sv -----
module tstt_ctrl #(
    parameter int TABLE_ENTRIES = tstt_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = tstt_pkg::ID_BITS_DEF,
    localparam int AW           = $clog2(TABLE_ENTRIES),
    localparam int END_LSB      = 0,
    localparam int EM_LSB       = END_LSB + tstt_pkg::WORD_BITS,
    localparam int ID_LSB       = EM_LSB + tstt_pkg::WORD_BITS,
    localparam int LOOP_BIT     = ID_LSB + ID_BITS,
    localparam int VALID_BIT    = LOOP_BIT + 1,
    localparam int EW           = VALID_BIT + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_cmd,
    input  logic [tstt_pkg::WORD_BITS-1:0] i_sound_id,
    input  logic [tstt_pkg::WORD_BITS-1:0] i_emitter,
    input  logic                           i_repeating,
    input  logic [tstt_pkg::WORD_BITS-1:0] i_length_ms,
    input  logic [tstt_pkg::WORD_BITS-1:0] i_now_ms,
    input  tstt_pkg::t_cfg                 i_cfg,
    output logic                           o_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [EW-1:0]                  o_wdata,
    output logic [AW-1:0]                  o_raddr,
    input  logic [EW-1:0]                  i_rdata,
    output logic                           o_res_valid,
    output tstt_pkg::t_result              o_res
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    // control state
    tstt_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_issue_done, n_issue_done;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [tstt_pkg::WORD_BITS-1:0] r_last_purge, n_last_purge;
    logic             r_res_valid, n_res_valid;

    // latched command and scan results
    tstt_pkg::t_cmd                 r_cmd, n_cmd;
    logic [tstt_pkg::WORD_BITS-1:0] r_id, n_id;
    logic [tstt_pkg::WORD_BITS-1:0] r_emitter, n_emitter;
    logic                           r_rep, n_rep;
    logic [tstt_pkg::WORD_BITS-1:0] r_end, n_end;
    logic [tstt_pkg::WORD_BITS-1:0] r_now, n_now;
    logic                           r_stop_em, n_stop_em;
    logic [tstt_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic                           r_playing, n_playing;
    logic                           r_free_found, n_free_found;
    logic [AW-1:0]                  r_free_idx, n_free_idx;
    tstt_pkg::t_result              r_res, n_res;

    // decode of the incoming command
    tstt_pkg::t_cmd                 w_cmd;
    logic [tstt_pkg::WORD_BITS-1:0] w_length;
    logic                           w_purge_due;
    logic                           w_skip;
    logic                           w_accept;

    // fields of the entry under scan
    logic                           w_ent_valid;
    logic                           w_ent_loops;
    logic [tstt_pkg::WORD_BITS-1:0] w_ent_id;
    logic [tstt_pkg::WORD_BITS-1:0] w_ent_em;
    logic [tstt_pkg::WORD_BITS-1:0] w_ent_end;
    logic                           w_id_eq;
    logic                           w_em_eq;
    logic                           w_remove;
    logic                           w_live;
    logic                           w_scan_last;

    assign w_cmd       = tstt_pkg::t_cmd'(i_cmd);
    assign w_length    = i_repeating ? tstt_pkg::WORD_BITS'(1) : i_length_ms;
    assign w_purge_due = (i_now_ms - r_last_purge) >=
                         tstt_pkg::WORD_BITS'(i_cfg.purge_interval_ms);
    assign w_skip      = ((w_cmd == tstt_pkg::CMD_START) && (w_length == '0)) ||
                         ((w_cmd == tstt_pkg::CMD_PURGE) && !w_purge_due);
    assign w_accept    = i_start && (r_state == tstt_pkg::ST_IDLE);

    assign w_ent_valid = i_rdata[VALID_BIT];
    assign w_ent_loops = i_rdata[LOOP_BIT];
    assign w_ent_id    = tstt_pkg::WORD_BITS'(i_rdata[ID_LSB +: ID_BITS]);
    assign w_ent_em    = i_rdata[EM_LSB +: tstt_pkg::WORD_BITS];
    assign w_ent_end   = i_rdata[END_LSB +: tstt_pkg::WORD_BITS];
    assign w_id_eq     = (w_ent_id == r_id);
    assign w_em_eq     = (w_ent_em == r_emitter);
    assign w_scan_last = r_pend && (r_paddr == LAST_ADDR);

    // per-entry match for the command being scanned
    always_comb begin
        w_remove = 1'b0;
        w_live   = 1'b0;
        unique case (r_cmd)
            tstt_pkg::CMD_START: begin
                w_remove = w_ent_valid && r_stop_em && w_em_eq;
            end
            tstt_pkg::CMD_STOP: begin
                if (r_id != '0) begin
                    w_remove = w_ent_valid && w_id_eq && w_em_eq;
                end else begin
                    w_remove = w_ent_valid && ((r_emitter == '0) || w_em_eq);
                end
            end
            tstt_pkg::CMD_QUERY: begin
                w_live = w_ent_valid && ((r_id != '0) || (r_emitter != '0)) &&
                         w_em_eq && ((r_id == '0) || w_id_eq) &&
                         (w_ent_loops || (w_ent_end > r_now));
            end
            tstt_pkg::CMD_PURGE: begin
                w_remove = w_ent_valid && !w_ent_loops && (w_ent_end < r_now);
            end
            default: begin
                w_remove = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tstt_pkg::ST_CLEAR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = tstt_pkg::ST_IDLE;
                end
            end
            tstt_pkg::ST_IDLE: begin
                if (w_accept && !w_skip) begin
                    n_state = tstt_pkg::ST_SCAN;
                end
            end
            tstt_pkg::ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = tstt_pkg::ST_FINISH;
                end
            end
            tstt_pkg::ST_FINISH: begin
                n_state = tstt_pkg::ST_IDLE;
            end
            default: begin
                n_state = tstt_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_pend       = 1'b0;
        n_paddr      = r_paddr;
        n_last_purge = r_last_purge;
        n_res_valid  = 1'b0;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_emitter    = r_emitter;
        n_rep        = r_rep;
        n_end        = r_end;
        n_now        = r_now;
        n_stop_em    = r_stop_em;
        n_count      = r_count;
        n_playing    = r_playing;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res        = r_res;
        o_we         = 1'b0;
        o_waddr      = r_addr;
        o_wdata      = '0;
        o_busy       = (r_state != tstt_pkg::ST_IDLE);

        unique case (r_state)
            // clearing pass over all entries after reset
            tstt_pkg::ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_addr;
                o_wdata = '0;
                n_addr  = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            // take a command, answer at once when no scan is needed
            tstt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd        = w_cmd;
                    n_id         = i_sound_id;
                    n_emitter    = i_emitter;
                    n_rep        = i_repeating;
                    n_end        = i_now_ms + w_length;
                    n_now        = i_now_ms;
                    n_stop_em    = (i_emitter != '0) && i_cfg.one_per_emitter;
                    n_count      = '0;
                    n_playing    = 1'b0;
                    n_free_found = 1'b0;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    if (w_skip) begin
                        n_res       = '0;
                        n_res_valid = 1'b1;
                    end else if (w_cmd == tstt_pkg::CMD_PURGE) begin
                        n_last_purge = i_now_ms;
                    end
                end
            end
            // issue one read a cycle, update the entry read the cycle before
            tstt_pkg::ST_SCAN: begin
                if (!r_issue_done) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr;
                    if (r_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_pend) begin
                    if (w_remove) begin
                        o_we               = 1'b1;
                        o_waddr            = r_paddr;
                        o_wdata            = i_rdata;
                        o_wdata[VALID_BIT] = 1'b0;
                        if (r_count != tstt_pkg::COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    if (w_live) begin
                        n_playing = 1'b1;
                    end
                    if (!r_free_found && (!w_ent_valid || w_remove)) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_paddr;
                    end
                end
            end
            // store a new sound on a start with a free entry, and post the result
            tstt_pkg::ST_FINISH: begin
                n_res.stopped_count = r_count;
                n_res.is_playing    = r_playing;
                n_res.accepted      = 1'b0;
                n_res.table_full    = 1'b0;
                n_res_valid         = 1'b1;
                if (r_cmd == tstt_pkg::CMD_START) begin
                    if (r_free_found) begin
                        o_we           = 1'b1;
                        o_waddr        = r_free_idx;
                        o_wdata        = {1'b1, r_rep, r_id[ID_BITS-1:0], r_emitter, r_end};
                        n_res.accepted = 1'b1;
                    end else begin
                        n_res.table_full = 1'b1;
                    end
                end else if (r_cmd == tstt_pkg::CMD_PURGE) begin
                    // expired entries are not reported as stopped
                    n_res.stopped_count = '0;
                    n_res.accepted      = 1'b1;
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_raddr     = r_addr;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tstt_pkg::ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_last_purge <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_pend       <= n_pend;
            r_last_purge <= n_last_purge;
            r_res_valid  <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_paddr      <= n_paddr;
        r_cmd        <= n_cmd;
        r_id         <= n_id;
        r_emitter    <= n_emitter;
        r_rep        <= n_rep;
        r_end        <= n_end;
        r_now        <= n_now;
        r_stop_em    <= n_stop_em;
        r_count      <= n_count;
        r_playing    <= n_playing;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res        <= n_res;
    end

endmodule

// ----- design/timed_sound_tracking_table.sv -----
// Timed sound tracking table: a table of active sounds kept in one
// synchronous memory, one entry per sound.
// Command channel: a command (start, stop, query, purge) with its fields is
// transferred at a clock edge where start is high and busy is low; busy
// stays high while the command works on the table.
// Result channel: every command yields one result, shown for one cycle with
// o_result_valid; the receiver cannot stall it.
// Timing: a start of length zero and a purge that comes too soon answer
// without touching the table, the result being registered at the
// transfer. Every other command scans the whole table through the one read
// port of the memory, one entry a cycle with the write-back of a removed
// entry on the write port, and then a finish state registers the result;
// busy drops in the result cycle, so the next command may be transferred
// at the edge that takes the result.
// Reset: a clearing pass writes every entry invalid with busy high;
// configuration writes are taken at any time and return to their reset
// values (one per emitter off, purge interval 2000 ms).
module timed_sound_tracking_table #(
    parameter int TABLE_ENTRIES = tstt_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = tstt_pkg::ID_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_cmd,
    input  logic [tstt_pkg::WORD_BITS-1:0]       i_sound_id,
    input  logic [tstt_pkg::WORD_BITS-1:0]       i_emitter,
    input  logic                                 i_repeating,
    input  logic [tstt_pkg::WORD_BITS-1:0]       i_length_ms,
    input  logic [tstt_pkg::WORD_BITS-1:0]       i_now_ms,
    output logic                                 o_result_valid,
    output logic [tstt_pkg::COUNT_BITS-1:0]      o_stopped_count,
    output logic                                 o_is_playing,
    output logic                                 o_accepted,
    output logic                                 o_table_full,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tstt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [tstt_pkg::PURGE_BITS-1:0]      i_cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 2 + ID_BITS + 2 * tstt_pkg::WORD_BITS;

    tstt_pkg::t_cfg    r_cfg;
    tstt_pkg::t_result w_res;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [EW-1:0]     w_rdata;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_per_emitter   <= 1'b0;
            r_cfg.purge_interval_ms <= tstt_pkg::PURGE_INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tstt_pkg::CFG_ONE_PER_EMITTER) begin
                r_cfg.one_per_emitter <= i_cfg_data[0];
            end else if (i_cfg_index == tstt_pkg::CFG_PURGE_INTERVAL) begin
                r_cfg.purge_interval_ms <= i_cfg_data;
            end
        end
    end

    // command sequencer
    tstt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BITS       (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_sound_id  (i_sound_id),
        .i_emitter   (i_emitter),
        .i_repeating (i_repeating),
        .i_length_ms (i_length_ms),
        .i_now_ms    (i_now_ms),
        .i_cfg       (r_cfg),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (o_result_valid),
        .o_res       (w_res)
    );

    // entry memory
    tstt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result fields
    assign o_stopped_count = w_res.stopped_count;
    assign o_is_playing    = w_res.is_playing;
    assign o_accepted      = w_res.accepted;
    assign o_table_full    = w_res.table_full;

endmodule

// ----- dv/tb_timed_sound_tracking_table.sv -----
`timescale 1ns / 1ps

module tb_timed_sound_tracking_table;
    import tstt_pkg::*;

    localparam int ENTRIES         = TABLE_ENTRIES_DEF;
    localparam int IDW             = ID_BITS_DEF;
    localparam int IDLE_LIMIT      = 1000;
    localparam int TAIL_CYCLES     = 80;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int FILL_BURST      = 70;

    // clock, reset and block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd       = CMD_QUERY;
    logic [WORD_BITS-1:0]  i_sound_id  = '0;
    logic [WORD_BITS-1:0]  i_emitter   = '0;
    logic                  i_repeating = 1'b0;
    logic [WORD_BITS-1:0]  i_length_ms = '0;
    logic [WORD_BITS-1:0]  i_now_ms    = '0;
    logic                  o_result_valid;
    logic [COUNT_BITS-1:0] o_stopped_count;
    logic                  o_is_playing;
    logic                  o_accepted;
    logic                  o_table_full;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_ONE_PER_EMITTER;
    logic [PURGE_BITS-1:0]   i_cfg_data  = '0;

    // shadow copy of the sound table and its registers
    logic                  snd_valid   [ENTRIES];
    logic [IDW-1:0]        snd_id      [ENTRIES];
    logic [WORD_BITS-1:0]  snd_emitter [ENTRIES];
    logic [WORD_BITS-1:0]  snd_end     [ENTRIES];
    logic                  snd_loops   [ENTRIES];
    logic [WORD_BITS-1:0]  last_purge_ms;
    logic                  cfg_one_per_emitter;
    logic [PURGE_BITS-1:0] cfg_purge_interval;

    t_result pending_results [$];
    logic    gaps_on = 1'b1;
    int      n_errors = 0;
    int      quiet_cycles = 0;
    int      n_cmds = 0, n_stored = 0, n_full = 0, n_removed = 0;
    int      n_live = 0, n_purged = 0, n_cfg_writes = 0;

    timed_sound_tracking_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_sound_id      (i_sound_id),
        .i_emitter       (i_emitter),
        .i_repeating     (i_repeating),
        .i_length_ms     (i_length_ms),
        .i_now_ms        (i_now_ms),
        .o_result_valid  (o_result_valid),
        .o_stopped_count (o_stopped_count),
        .o_is_playing    (o_is_playing),
        .o_accepted      (o_accepted),
        .o_table_full    (o_table_full),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // clear entries that match id and emitter, id zero meaning any
    function automatic int drop_matching(logic [WORD_BITS-1:0] id,
                                         logic [WORD_BITS-1:0] em);
        int cnt;
        int i;
        logic hit;
        cnt = 0;
        for (i = 0; i < ENTRIES; i++) begin
            if (snd_valid[i]) begin
                if (id != 0)
                    hit = ({{(WORD_BITS-IDW){1'b0}}, snd_id[i]} == id) && (snd_emitter[i] == em);
                else
                    hit = (em == 0) || (snd_emitter[i] == em);
                if (hit) begin
                    snd_valid[i] = 1'b0;
                    cnt++;
                end
            end
        end
        return cnt;
    endfunction

    // apply one command to the shadow table and return its result
    function automatic t_result model_sound_cmd(t_cmd cmd, logic [WORD_BITS-1:0] id,
            logic [WORD_BITS-1:0] em, logic rep, logic [WORD_BITS-1:0] len,
            logic [WORD_BITS-1:0] now);
        t_result res;
        logic [WORD_BITS-1:0] dur;
        int removed;
        int slot;
        int i;
        res = '0;
        removed = 0;
        slot = -1;
        case (cmd)
            CMD_START: begin
                dur = rep ? 32'd1 : len;
                if (dur != 0) begin
                    if (em != 0 && cfg_one_per_emitter)
                        removed = drop_matching('0, em);
                    for (i = 0; i < ENTRIES; i++) begin
                        if (!snd_valid[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot < 0) begin
                        res.table_full = 1'b1;
                    end else begin
                        snd_valid[slot]   = 1'b1;
                        snd_id[slot]      = id[IDW-1:0];
                        snd_emitter[slot] = em;
                        snd_loops[slot]   = rep;
                        snd_end[slot]     = now + dur;
                        res.accepted      = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                removed = drop_matching(id, em);
            end
            CMD_QUERY: begin
                if (id != 0 || em != 0) begin
                    for (i = 0; i < ENTRIES; i++) begin
                        if (snd_valid[i] && snd_emitter[i] == em &&
                            (id == 0 || {{(WORD_BITS-IDW){1'b0}}, snd_id[i]} == id) &&
                            (snd_loops[i] || snd_end[i] > now)) begin
                            res.is_playing = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: begin
                if (now - last_purge_ms >= {16'd0, cfg_purge_interval}) begin
                    last_purge_ms = now;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (snd_valid[i] && !snd_loops[i] && snd_end[i] < now)
                            snd_valid[i] = 1'b0;
                    end
                    res.accepted = 1'b1;
                end
            end
        endcase
        res.stopped_count = (removed > COUNT_MAX) ? COUNT_MAX : removed[COUNT_BITS-1:0];
        return res;
    endfunction

    // drive one command and wait for its transfer; called at a falling edge
    task automatic send_item(t_cmd cmd, logic [WORD_BITS-1:0] id, logic [WORD_BITS-1:0] em,
                             logic rep, logic [WORD_BITS-1:0] len,
                             logic [WORD_BITS-1:0] now);
        t_result res;
        i_cmd       = cmd;
        i_sound_id  = id;
        i_emitter   = em;
        i_repeating = rep;
        i_length_ms = len;
        i_now_ms    = now;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
        res = model_sound_cmd(cmd, id, em, rep, len, now);
        pending_results.push_back(res);
        n_cmds++;
        n_stored  += res.accepted && cmd == CMD_START;
        n_purged  += res.accepted && cmd == CMD_PURGE;
        n_full    += res.table_full;
        n_live    += res.is_playing;
        n_removed += res.stopped_count;
        @(negedge i_clk);
        // sender gap
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_results_done();
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one register write transfer; called at a falling edge while idle
    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [PURGE_BITS-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ONE_PER_EMITTER)
            cfg_one_per_emitter = data[0];
        else if (idx == CFG_PURGE_INTERVAL)
            cfg_purge_interval = data;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding");
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("stopped_count", want.stopped_count, o_stopped_count);
                check_field("is_playing", want.is_playing, o_is_playing);
                check_field("accepted", want.accepted, o_accepted);
                check_field("table_full", want.table_full, o_table_full);
            end
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("tb_timed_sound_tracking_table: done, errors");
                $finish;
            end
        end
    end

    // zero length, looping start, flag bits and end time wrap
    task automatic test_start_edges();
        send_item(CMD_START, 32'h0000_0005, 32'd7, 1'b0, 32'd0, 32'd10);
        send_item(CMD_START, 32'hAB00_0011, 32'd7, 1'b1, 32'd0, 32'd10);
        send_item(CMD_START, 32'hFF12_3456, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'd10);
        send_item(CMD_START, 32'h0000_0022, 32'd0, 1'b0, 32'd50, 32'd10);
    endtask

    // stop and query matching rules
    task automatic test_stop_query_edges();
        send_item(CMD_QUERY, 32'h0012_3456, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd8);
        send_item(CMD_QUERY, 32'h0012_3456, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd9);
        send_item(CMD_QUERY, 32'hFF12_3456, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd8);
        send_item(CMD_QUERY, 32'd0, 32'd7, 1'b0, 32'd0, 32'd100);
        send_item(CMD_QUERY, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0);
        send_item(CMD_STOP, 32'hFF12_3456, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd20);
        send_item(CMD_STOP, 32'h0000_0011, 32'd0, 1'b0, 32'd0, 32'd20);
        send_item(CMD_QUERY, 32'h0000_0022, 32'd0, 1'b0, 32'd0, 32'd59);
    endtask

    // purge rate limit, expiry and backward time
    task automatic test_purge_edges();
        send_item(CMD_PURGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd1999);
        send_item(CMD_PURGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd2000);
        send_item(CMD_QUERY, 32'h0000_0022, 32'd0, 1'b0, 32'd0, 32'd0);
        send_item(CMD_PURGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd2001);
        send_item(CMD_PURGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'h0000_0100);
    endtask

    // start replacing an emitter's sounds, stop all
    task automatic test_one_per_emitter();
        wait_results_done();
        write_cfg(CFG_ONE_PER_EMITTER, 16'h0001);
        write_cfg(CFG_PURGE_INTERVAL, 16'h0000);
        send_item(CMD_START, 32'd1, 32'd7, 1'b0, 32'd100, 32'd300);
        send_item(CMD_START, 32'd2, 32'd7, 1'b0, 32'd100, 32'd300);
        send_item(CMD_START, 32'd3, 32'd0, 1'b0, 32'd100, 32'd300);
        send_item(CMD_START, 32'd3, 32'd0, 1'b0, 32'd100, 32'd300);
        send_item(CMD_STOP, 32'd0, 32'd0, 1'b0, 32'd0, 32'd300);
        send_item(CMD_PURGE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd300);
    endtask

    // random traffic over small id and emitter sets, with table fill bursts
    task automatic test_random_traffic();
        logic [WORD_BITS-1:0]  id_pool [6];
        logic [WORD_BITS-1:0]  em_pool [4];
        logic [WORD_BITS-1:0]  now_ms;
        logic [WORD_BITS-1:0]  id, em, len;
        logic [PURGE_BITS-1:0] ivl;
        logic                  opm, rep;
        t_cmd                  cmd;
        int                    ph, n, r, fill_left, k;
        now_ms = 32'd400;
        fill_left = 0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_results_done();
            case (ph)
                0: begin opm = 1'b0; ivl = 16'hFFFF; end
                1: begin opm = 1'b1; ivl = PURGE_INTERVAL_RST; end
                2: begin opm = 1'b0; ivl = 16'h0000; end
                3: begin opm = 1'b1; ivl = 16'($urandom_range(0, 65535)); end
                4: begin opm = 1'b0; ivl = 16'($urandom_range(1, 400)); end
                default: begin opm = 1'b1; ivl = 16'hFFFF; end
            endcase
            write_cfg(CFG_ONE_PER_EMITTER, {15'($urandom), opm});
            write_cfg(CFG_PURGE_INTERVAL, ivl);
            gaps_on = (ph != RAND_PHASES - 1);
            for (k = 0; k < 6; k++) id_pool[k] = $urandom_range(1, (1 << IDW) - 1);
            em_pool[0] = '0;
            for (k = 1; k < 4; k++) em_pool[k] = $urandom;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // time mostly creeps forward, now and then jumps or nears wrap
                r = $urandom_range(0, 99);
                if (r < 85)
                    now_ms += $urandom_range(0, 200);
                else if (r < 93)
                    now_ms += $urandom_range(0, 20000);
                else if (r < 97)
                    now_ms = $urandom;
                else
                    now_ms = 32'hFFFF_FF00 | $urandom_range(0, 255);
                r = $urandom_range(0, 99);
                if (r < 10)
                    id = '0;
                else if (r < 20)
                    id = id_pool[$urandom_range(0, 5)] | ($urandom & 32'hFF00_0000);
                else if (r < 25)
                    id = $urandom;
                else
                    id = id_pool[$urandom_range(0, 5)];
                em  = em_pool[$urandom_range(0, 3)];
                rep = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = '0;
                else if (r < 10)
                    len = $urandom;
                else
                    len = $urandom_range(1, 3000);
                if (fill_left > 0) begin
                    cmd = CMD_START;
                    fill_left--;
                    if ($urandom_range(0, 1) == 0)
                        em = '0;
                    else
                        em = $urandom;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r == 0) begin
                        fill_left = FILL_BURST;
                        cmd = CMD_START;
                    end else if (r < 41) begin
                        cmd = CMD_START;
                    end else if (r < 61) begin
                        cmd = CMD_STOP;
                    end else if (r < 88) begin
                        cmd = CMD_QUERY;
                    end else begin
                        cmd = CMD_PURGE;
                    end
                end
                send_item(cmd, id, em, rep, len, now_ms);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            snd_valid[i]   = 1'b0;
            snd_id[i]      = '0;
            snd_emitter[i] = '0;
            snd_end[i]     = '0;
            snd_loops[i]   = 1'b0;
        end
        last_purge_ms       = '0;
        cfg_one_per_emitter = 1'b0;
        cfg_purge_interval  = PURGE_INTERVAL_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_start_edges();
        test_stop_query_edges();
        test_purge_edges();
        test_one_per_emitter();
        test_random_traffic();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_errors++;
        end
        $display("covered %0d commands: %0d sounds stored, %0d refused on a full table",
                 n_cmds, n_stored, n_full);
        $display("  %0d sounds stopped, %0d live answers, %0d purges run, %0d register writes",
                 n_removed, n_live, n_purged, n_cfg_writes);
        if (n_errors == 0)
            $display("tb_timed_sound_tracking_table: done, clean");
        else
            $display("tb_timed_sound_tracking_table: done, errors");
        $finish;
    end

endmodule
